[hw/rtl/hsv2rgb_pkg.sv]
// Shared types and constants for the HSV to RGB color conversion pipeline.
package hsv2rgb_pkg;

	typedef struct packed {
		logic [8:0] hue_deg;
		logic [6:0] sat_pct;
		logic [6:0] val_pct;
	} hsv_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       range_error;
	} rgb_t;

	// Legal input limits.
	localparam logic [8:0] HUE_LIMIT = 9'd359;
	localparam logic [6:0] PCT_LIMIT = 7'd100;

	// Hue sector codes (hue / 60).
	localparam logic [2:0] SEC_RED_YEL = 3'd0;
	localparam logic [2:0] SEC_YEL_GRN = 3'd1;
	localparam logic [2:0] SEC_GRN_CYN = 3'd2;
	localparam logic [2:0] SEC_CYN_BLU = 3'd3;
	localparam logic [2:0] SEC_BLU_MAG = 3'd4;
	localparam logic [2:0] SEC_MAG_RED = 3'd5;

	// Level lanes: full value, floor level p, falling ramp q, rising ramp t.
	localparam int LVL_N = 4;
	localparam int LVL_V = 0;
	localparam int LVL_P = 1;
	localparam int LVL_Q = 2;
	localparam int LVL_T = 3;

	// Every level is floor(v * m * 17 / 40000) with m at most 6000.
	localparam int M_W         = 13;
	localparam int N_W         = 20;
	localparam int Y_W         = 18;
	localparam int FULL_RAMP   = 6000;
	localparam int SECTOR_DEG  = 60;
	localparam int PRE_SHIFT   = 6;
	localparam int DIV_LOW     = 625;
	localparam int RECIP_W     = 15;
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP       = (1 << RECIP_SHIFT) / DIV_LOW;

	// Cycles from an accepted transaction to its result strobe edge.
	localparam int PIPE_LAT = 6;

endpackage

[hw/rtl/hsv_to_rgb_converter.sv]
// HSV to RGB color conversion, six-stage pipeline.
//
// Converts one color per clock: hue in whole degrees (0..359), saturation
// and value in percent (0..100) become 8-bit red, green and blue, computed
// exactly with truncating integer arithmetic. A transaction is taken on every
// rising edge where start is high; busy never rises, so a new color can be
// issued in every cycle. The result appears on rgb with done high for exactly
// one cycle, and results leave in the order the colors arrived. The receiver
// cannot stall the block, so each result must be captured in its strobe
// cycle. Latency is set by the four-lane level datapath: sector split, ramp
// products, value product, scaling, reciprocal multiply and remainder
// correction each own a stage. If the hue exceeds 359, or the saturation or
// value exceeds 100, the result carries zero colors and range_error set.
module hsv_to_rgb_converter
	import hsv2rgb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  hsv_t hsv,
	output logic done,
	output rgb_t rgb
);

	logic accept;
	assign accept = start && !busy;
	assign busy   = 1'b0;

	// Stage 1: range check and split of the hue into sector and offset.
	logic [2:0] sec_in;
	logic [8:0] base_in;
	logic [8:0] off_in;
	logic       err_in;

	always_comb begin
		if (hsv.hue_deg >= 9'd300) begin
			sec_in = SEC_MAG_RED;
		end else if (hsv.hue_deg >= 9'd240) begin
			sec_in = SEC_BLU_MAG;
		end else if (hsv.hue_deg >= 9'd180) begin
			sec_in = SEC_CYN_BLU;
		end else if (hsv.hue_deg >= 9'd120) begin
			sec_in = SEC_GRN_CYN;
		end else if (hsv.hue_deg >= 9'd60) begin
			sec_in = SEC_YEL_GRN;
		end else begin
			sec_in = SEC_RED_YEL;
		end
		base_in = 9'(sec_in) * 9'(SECTOR_DEG);
		off_in  = hsv.hue_deg - base_in;
		err_in  = (hsv.hue_deg > HUE_LIMIT) || (hsv.sat_pct > PCT_LIMIT) ||
			(hsv.val_pct > PCT_LIMIT);
	end

	logic       vld_s1;
	logic       err_s1;
	logic [2:0] sec_s1;
	logic [5:0] f_s1;
	logic [6:0] sat_s1;
	logic [6:0] val_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		err_s1 <= err_in;
		sec_s1 <= sec_in;
		f_s1   <= off_in[5:0];
		sat_s1 <= hsv.sat_pct;
		val_s1 <= hsv.val_pct;
	end

	// Stage 2: the multiplier m of each level lane (v * m * 17 / 40000).
	// The full level uses 6000 and p uses 6000 - 60 s, which keeps all four
	// lanes on one datapath.
	logic [M_W-1:0] m_in [LVL_N];

	always_comb begin
		m_in[LVL_V] = M_W'(FULL_RAMP);
		m_in[LVL_P] = M_W'(FULL_RAMP) - M_W'(sat_s1) * M_W'(SECTOR_DEG);
		m_in[LVL_Q] = M_W'(FULL_RAMP) - M_W'(sat_s1) * M_W'(f_s1);
		m_in[LVL_T] = M_W'(FULL_RAMP) -
			M_W'(sat_s1) * M_W'(6'(SECTOR_DEG) - f_s1);
	end

	logic           vld_s2;
	logic           err_s2;
	logic [2:0]     sec_s2;
	logic [6:0]     val_s2;
	logic [M_W-1:0] m_s2 [LVL_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		err_s2 <= err_s1;
		sec_s2 <= sec_s1;
		val_s2 <= val_s1;
		m_s2   <= m_in;
	end

	// Stage 3: value times lane multiplier.
	logic           vld_s3;
	logic           err_s3;
	logic [2:0]     sec_s3;
	logic [N_W-1:0] n_s3 [LVL_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		err_s3 <= err_s2;
		sec_s3 <= sec_s2;
		for (int i = 0; i < LVL_N; i++) begin
			n_s3[i] <= N_W'(val_s2) * N_W'(m_s2[i]);
		end
	end

	// Stage 4: scale by 17 and drop the power-of-two part of 40000.
	logic [N_W+4:0] x17 [LVL_N];

	always_comb begin
		for (int i = 0; i < LVL_N; i++) begin
			x17[i] = ((N_W+5)'(n_s3[i]) << 4) + (N_W+5)'(n_s3[i]);
		end
	end

	logic           vld_s4;
	logic           err_s4;
	logic [2:0]     sec_s4;
	logic [Y_W-1:0] y_s4 [LVL_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		err_s4 <= err_s3;
		sec_s4 <= sec_s3;
		for (int i = 0; i < LVL_N; i++) begin
			y_s4[i] <= x17[i][PRE_SHIFT +: Y_W];
		end
	end

	// Stage 5: quotient estimate by the truncated reciprocal of 625. The
	// estimate is the true quotient or one below it.
	logic [Y_W+RECIP_W-1:0] rp [LVL_N];

	always_comb begin
		for (int i = 0; i < LVL_N; i++) begin
			rp[i] = (Y_W+RECIP_W)'(y_s4[i]) * (Y_W+RECIP_W)'(RECIP);
		end
	end

	logic           vld_s5;
	logic           err_s5;
	logic [2:0]     sec_s5;
	logic [7:0]     q0_s5 [LVL_N];
	logic [Y_W-1:0] y_s5  [LVL_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		err_s5 <= err_s4;
		sec_s5 <= sec_s4;
		y_s5   <= y_s4;
		for (int i = 0; i < LVL_N; i++) begin
			q0_s5[i] <= rp[i][RECIP_SHIFT +: 8];
		end
	end

	// Stage 6: remainder correction, channel mapping and the result register.
	logic [Y_W-1:0] rem [LVL_N];
	logic [7:0]     lvl [LVL_N];
	rgb_t           rgb_in;

	always_comb begin
		for (int i = 0; i < LVL_N; i++) begin
			rem[i] = y_s5[i] - Y_W'(q0_s5[i]) * Y_W'(DIV_LOW);
			lvl[i] = q0_s5[i] + 8'(rem[i] >= Y_W'(DIV_LOW));
		end
		rgb_in.range_error = err_s5;
		case (sec_s5)
			SEC_RED_YEL: begin
				rgb_in.red = lvl[LVL_V]; rgb_in.green = lvl[LVL_T]; rgb_in.blue = lvl[LVL_P];
			end
			SEC_YEL_GRN: begin
				rgb_in.red = lvl[LVL_Q]; rgb_in.green = lvl[LVL_V]; rgb_in.blue = lvl[LVL_P];
			end
			SEC_GRN_CYN: begin
				rgb_in.red = lvl[LVL_P]; rgb_in.green = lvl[LVL_V]; rgb_in.blue = lvl[LVL_T];
			end
			SEC_CYN_BLU: begin
				rgb_in.red = lvl[LVL_P]; rgb_in.green = lvl[LVL_Q]; rgb_in.blue = lvl[LVL_V];
			end
			SEC_BLU_MAG: begin
				rgb_in.red = lvl[LVL_T]; rgb_in.green = lvl[LVL_P]; rgb_in.blue = lvl[LVL_V];
			end
			default: begin
				rgb_in.red = lvl[LVL_V]; rgb_in.green = lvl[LVL_P]; rgb_in.blue = lvl[LVL_Q];
			end
		endcase
		if (err_s5) begin
			rgb_in.red   = 8'd0;
			rgb_in.green = 8'd0;
			rgb_in.blue  = 8'd0;
		end
	end

	logic vld_s6;
	rgb_t rgb_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		rgb_s6 <= rgb_in;
	end

	assign done = vld_s6;
	assign rgb  = rgb_s6;

endmodule

[hw/rtl/hsv2rgb_chk.sv]
// Port-level checker for the HSV to RGB converter, with its bind statement.
module hsv2rgb_chk
	import hsv2rgb_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input hsv_t hsv,
	input logic done,
	input rgb_t rgb
);

	// Every result strobe traces back to an earlier accepted transaction.
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result strobe without a matching transaction");

	// The error flag reflects the range of the inputs of that transaction.
	a_err_matches_input: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rgb.range_error == $past((hsv.hue_deg > HUE_LIMIT) ||
			(hsv.sat_pct > PCT_LIMIT) || (hsv.val_pct > PCT_LIMIT), PIPE_LAT)))
		else $error("range_error does not match the transaction inputs");

	// An out-of-range transaction gives black.
	a_err_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rgb.range_error) |-> (rgb.red == 8'd0 && rgb.green == 8'd0 &&
			rgb.blue == 8'd0))
		else $error("colors not zero on a range error");

	// Zero saturation gives a gray: all channels equal.
	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rgb.range_error && $past(hsv.sat_pct == 7'd0, PIPE_LAT)) |->
			(rgb.red == rgb.green && rgb.green == rgb.blue))
		else $error("zero saturation did not give equal channels");

endmodule

bind hsv_to_rgb_converter hsv2rgb_chk u_hsv2rgb_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.hsv    (hsv),
	.done   (done),
	.rgb    (rgb)
);

[tb/hsv_to_rgb_converter_tb.sv]
// Self-checking testbench for the HSV to RGB color converter, with its scoreboard.
module hsv_to_rgb_converter_tb;
	import hsv2rgb_pkg::*;

	// The converter has no stall path, so a result that is still missing after this many
	// quiet cycles means the run is stuck.
	localparam int QUIET_LIMIT = 2000;
	localparam int NUM_RANDOM  = 800;

	// The scoreboard predicts the RGB color for every accepted transaction and holds the
	// predictions in arrival order. The block keeps no state, so each prediction depends
	// only on its own transaction.
	class color_scoreboard;
		rgb_t expected_rgb[$];
		int   errors;
		int   colors_seen;
		int   range_errors_seen;
		int   results_checked;

		function new();
			errors = 0;
			colors_seen = 0;
			range_errors_seen = 0;
			results_checked = 0;
		endfunction

		task report(input string msg);
			errors++;
			$display("ERROR at %0t: %s", $time, msg);
		endtask

		// Integer HSV to RGB conversion with truncation. The hue sector picks how the full
		// level, the floor level and the two ramps map onto the three channels.
		function rgb_t predict_rgb(input hsv_t c);
			int unsigned hue;
			int unsigned sat;
			int unsigned val;
			int unsigned frac;
			int unsigned full_lvl;
			int unsigned floor_lvl;
			int unsigned fall_lvl;
			int unsigned rise_lvl;
			logic [2:0]  sector;
			rgb_t        res;
			hue = c.hue_deg;
			sat = c.sat_pct;
			val = c.val_pct;
			res = '0;
			if (hue > HUE_LIMIT || sat > PCT_LIMIT || val > PCT_LIMIT) begin
				res.range_error = 1'b1;
				return res;
			end
			sector    = 3'(hue / 60);
			frac      = hue % 60;
			full_lvl  = val * 255 / 100;
			floor_lvl = val * (100 - sat) * 255 / 10000;
			fall_lvl  = val * (6000 - sat * frac) * 255 / 600000;
			rise_lvl  = val * (6000 - sat * (60 - frac)) * 255 / 600000;
			case (sector)
				SEC_RED_YEL: begin
					res.red = 8'(full_lvl); res.green = 8'(rise_lvl); res.blue = 8'(floor_lvl);
				end
				SEC_YEL_GRN: begin
					res.red = 8'(fall_lvl); res.green = 8'(full_lvl); res.blue = 8'(floor_lvl);
				end
				SEC_GRN_CYN: begin
					res.red = 8'(floor_lvl); res.green = 8'(full_lvl); res.blue = 8'(rise_lvl);
				end
				SEC_CYN_BLU: begin
					res.red = 8'(floor_lvl); res.green = 8'(fall_lvl); res.blue = 8'(full_lvl);
				end
				SEC_BLU_MAG: begin
					res.red = 8'(rise_lvl); res.green = 8'(floor_lvl); res.blue = 8'(full_lvl);
				end
				default: begin
					res.red = 8'(full_lvl); res.green = 8'(floor_lvl); res.blue = 8'(fall_lvl);
				end
			endcase
			return res;
		endfunction

		function void note_color(input hsv_t c);
			rgb_t exp;
			exp = predict_rgb(c);
			colors_seen++;
			if (exp.range_error)
				range_errors_seen++;
			expected_rgb.push_back(exp);
		endfunction

		task check_result(input rgb_t got);
			rgb_t exp;
			if (expected_rgb.size() == 0) begin
				report($sformatf("result %p arrived with no color outstanding", got));
				return;
			end
			exp = expected_rgb.pop_front();
			results_checked++;
			if (got.red !== exp.red)
				report($sformatf("red: got %0d, expected %0d", got.red, exp.red));
			if (got.green !== exp.green)
				report($sformatf("green: got %0d, expected %0d", got.green, exp.green));
			if (got.blue !== exp.blue)
				report($sformatf("blue: got %0d, expected %0d", got.blue, exp.blue));
			if (got.range_error !== exp.range_error)
				report($sformatf("range_error: got %b, expected %b",
					got.range_error, exp.range_error));
		endtask

		function int pending();
			return expected_rgb.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	hsv_t hsv;
	logic done;
	rgb_t rgb;

	color_scoreboard sb = new();

	hsv_to_rgb_converter DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.hsv    (hsv),
		.done   (done),
		.rgb    (rgb)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Monitor. Everything is sampled at the rising edge, before the nonblocking updates of
	// that edge land, so the values seen are the ones the block itself saw. An input
	// transaction is taken when start is high and busy is low; a result is taken on done.
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_color(hsv);
		if (done)
			sb.check_result(rgb);
	end

	// Watchdog: any cycle with neither an input nor a result transaction counts as quiet.
	// Long sender gaps stay far below the limit, so only a hung block trips it.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((arst_n && start && !busy) || done)
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no transaction for %0d cycles, %0d results outstanding",
			QUIET_LIMIT, sb.pending());
		$display("Simulation FAILED");
		$finish;
	end

	function automatic hsv_t make_hsv(input int h, input int s, input int v);
		hsv_t c;
		c.hue_deg = 9'(h);
		c.sat_pct = 7'(s);
		c.val_pct = 7'(v);
		return c;
	endfunction

	// Idle cycles between colors: usually none, sometimes a few, rarely a long pause.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic int pick_pct();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 0;
		else if (r == 1)
			return 100;
		else
			return $urandom_range(0, 100);
	endfunction

	// Mostly legal colors with random content, with hue picked near sector borders now and
	// then. About one in six colors carries an out-of-range field or fully random bits, so
	// the error path and the top bits of every field are exercised.
	function automatic hsv_t random_color();
		int   r;
		hsv_t c;
		r = $urandom_range(0, 99);
		c = make_hsv($urandom_range(0, 359), pick_pct(), pick_pct());
		if ($urandom_range(0, 7) == 0)
			c.hue_deg = 9'(60 * $urandom_range(0, 5) + ($urandom_range(0, 1) ? 59 : 0));
		if (r < 5)
			c.hue_deg = 9'($urandom_range(360, 511));
		else if (r < 9)
			c.sat_pct = 7'($urandom_range(101, 127));
		else if (r < 13)
			c.val_pct = 7'($urandom_range(101, 127));
		else if (r < 17)
			c = hsv_t'(23'($urandom));
		return c;
	endfunction

	// Drives one color from a rising edge and holds it until the block takes it. With no
	// gap, start stays high and the next color follows in the very next cycle.
	task automatic send_color(input hsv_t c, input int gap);
		start <= 1'b1;
		hsv   <= c;
		do @(posedge clk); while (busy);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops sending and waits until every predicted result has come back. One edge passes
	// first so the monitor has noted the color taken at the edge this task starts on.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		hsv_t directed[$];
		bit   burst;
		int   gap;
		arst_n = 1'b0;
		start  = 1'b0;
		hsv    = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed colors: both ends of every sector, full and zero saturation and value,
		// and each field just past its legal limit and at its all-ones value.
		directed.push_back(make_hsv(0, 100, 100));
		directed.push_back(make_hsv(59, 100, 100));
		directed.push_back(make_hsv(60, 100, 100));
		directed.push_back(make_hsv(119, 100, 100));
		directed.push_back(make_hsv(120, 100, 100));
		directed.push_back(make_hsv(179, 100, 100));
		directed.push_back(make_hsv(180, 100, 100));
		directed.push_back(make_hsv(239, 100, 100));
		directed.push_back(make_hsv(240, 100, 100));
		directed.push_back(make_hsv(299, 100, 100));
		directed.push_back(make_hsv(300, 100, 100));
		directed.push_back(make_hsv(359, 100, 100));
		directed.push_back(make_hsv(200, 0, 100));
		directed.push_back(make_hsv(200, 100, 0));
		directed.push_back(make_hsv(0, 0, 0));
		directed.push_back(make_hsv(30, 50, 50));
		directed.push_back(make_hsv(330, 1, 99));
		directed.push_back(make_hsv(360, 100, 100));
		directed.push_back(make_hsv(511, 0, 0));
		directed.push_back(make_hsv(0, 101, 50));
		directed.push_back(make_hsv(0, 127, 50));
		directed.push_back(make_hsv(90, 50, 101));
		directed.push_back(make_hsv(90, 50, 127));
		directed.push_back(make_hsv(511, 127, 127));
		foreach (directed[i])
			send_color(directed[i], (i % 3 == 0) ? pick_gap() : 0);

		// Let the pipeline empty completely before the random part starts.
		drain_results();

		// Random part. Every block of 50 colors is either a back-to-back burst or uses
		// random gaps, so gaps land in every pipeline stage while full-rate stretches
		// still occur.
		burst = 1'b0;
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (n % 50 == 0)
				burst = ($urandom_range(0, 2) == 0);
			if (n == NUM_RANDOM / 2)
				drain_results();
			gap = burst ? 0 : pick_gap();
			send_color(random_color(), gap);
		end

		// Wait for the last results, then a few more cycles to catch any stray strobe.
		drain_results();
		repeat (PIPE_LAT + 4) @(posedge clk);

		$display("Converted %0d colors, %0d of them out of range; %0d results checked.",
			sb.colors_seen, sb.range_errors_seen, sb.results_checked);
		$display("Mismatches found: %0d", sb.errors);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
